// ===== rtl/swmf_pkg.sv =====
// shared types and constants for the sliding window median filter
// no dependencies; imported by every other file of the block
package swmf_pkg;

    localparam int WINDOW = 7;
    localparam int SAMPLE_W = 8;
    localparam int AGE_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int CFG_W = 3;
    localparam int FILL_W = 3;
    localparam logic [CFG_W-1:0] READY_MIN_RESET = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_OUT
    } swmf_state_t;

    // one window entry as held by a cell
    typedef struct packed {
        logic                valid;
        logic [AGE_W-1:0]    age;
        logic [SAMPLE_W-1:0] value;
    } swmf_entry_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;
        logic sort;
        logic parity;
    } swmf_ctl_t;

endpackage

// ===== rtl/swmf_cell.sv =====
// one cell of the sorted window chain: holds a sample and its age
// depends on swmf_pkg
module swmf_cell
    import swmf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  swmf_ctl_t           ctl,
    input  logic                is_first,
    input  logic                idx_odd,
    input  logic                full,
    input  logic [SAMPLE_W-1:0] sample,
    input  swmf_entry_t         lo_nb,
    input  swmf_entry_t         hi_nb,
    output swmf_entry_t         cur
);

    swmf_entry_t cur_reg, cur_next;
    logic load_here;
    logic lower_role;
    logic swap_hi;
    logic swap_lo;

    // full window: replace the oldest; filling: take the first empty slot
    assign load_here = full ? (cur_reg.valid && (cur_reg.age == AGE_W'(WINDOW - 1)))
                            : (!cur_reg.valid && (is_first || lo_nb.valid));
    assign lower_role = (idx_odd == ctl.parity);
    assign swap_hi = cur_reg.valid && hi_nb.valid && (cur_reg.value > hi_nb.value);
    assign swap_lo = lo_nb.valid && cur_reg.valid && (lo_nb.value > cur_reg.value);

    always_comb begin
        cur_next = cur_reg;
        if (ctl.load) begin
            if (load_here) begin
                cur_next.valid = 1'b1;
                cur_next.age   = '0;
                cur_next.value = sample;
            end else if (cur_reg.valid) begin
                cur_next.age = cur_reg.age + AGE_W'(1);
            end
        end else if (ctl.sort) begin
            // odd-even transposition with the neighbor of this round
            if (lower_role && swap_hi) begin
                cur_next = hi_nb;
            end else if (!lower_role && swap_lo) begin
                cur_next = lo_nb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

    assign cur = cur_reg;

endmodule

// ===== rtl/swmf_ctrl.sv =====
// sequencer: load, sorting rounds over the cell chain, result handshake
// depends on swmf_pkg
module swmf_ctrl
    import swmf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output swmf_ctl_t ctl
);

    swmf_state_t state_reg, state_next;
    logic [AGE_W-1:0] round_reg, round_next;
    logic last_round;

    assign last_round = (round_reg == AGE_W'(WINDOW - 1));

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_IDLE: begin
                round_next = '0;
                if (s_tvalid) begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                round_next = round_reg + AGE_W'(1);
                if (last_round) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctl        = '0;
        ctl.parity = round_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ctl.load = s_tvalid;
            end
            ST_SORT: begin
                ctl.sort = 1'b1;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

endmodule

// ===== rtl/sliding_window_median_filter.sv =====
// top level of the sliding window median filter: cell chain, sequencer, register
// depends on swmf_pkg, swmf_cell and swmf_ctrl
//
// Each accepted item carries one 8-bit sample and gives one result: the median
// of the samples held (element fill_count/2 of their ascending order, the upper
// median for an even count), a ready flag set once the fill count reaches
// ready_minimum, and the fill count itself. The window is kept sorted in a chain
// of WINDOW cells; a new sample takes the first empty cell, or once full replaces
// the oldest entry, and is moved into place by WINDOW rounds of odd-even neighbor
// exchange. Each item is loaded, sorted, then held until accepted; only then is
// the next item taken. Reset empties the window at once. The user must write
// ready_minimum on the cfg channel only while idle; the block does not enforce it.
module sliding_window_median_filter
    import swmf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] level_sample
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [7:0] median_level, [10:8] fill_count, rest zero
    output logic             m_tuser,   // [0] ready_res
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data   // ready_minimum
);

    swmf_ctl_t ctl;
    swmf_entry_t cells [WINDOW];
    swmf_entry_t lo_nb [WINDOW];
    swmf_entry_t hi_nb [WINDOW];
    logic full;
    logic [CFG_W-1:0] ready_min_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W+FILL_W-1:0] count_ext;
    logic [SAMPLE_W-1:0] median;
    logic [WINDOW-1:0] valid_vec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_min_reg <= READY_MIN_RESET;
        end else if (cfg_valid) begin
            ready_min_reg <= cfg_data;
        end
    end

    swmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    assign full = cells[WINDOW-1].valid;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            if (gi == 0) begin : g_lo_end
                assign lo_nb[gi] = '0;
            end else begin : g_lo
                assign lo_nb[gi] = cells[gi-1];
            end
            if (gi == WINDOW - 1) begin : g_hi_end
                assign hi_nb[gi] = '0;
            end else begin : g_hi
                assign hi_nb[gi] = cells[gi+1];
            end
            assign valid_vec[gi] = cells[gi].valid;

            swmf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .is_first (gi == 0),
                .idx_odd  ((gi % 2) == 1),
                .full     (full),
                .sample   (s_tdata[SAMPLE_W-1:0]),
                .lo_nb    (lo_nb[gi]),
                .hi_nb    (hi_nb[gi]),
                .cur      (cells[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctl.load && (count_reg < CNT_W'(WINDOW))) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // valid entries fill the low cells in ascending order
    always_comb begin
        median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if ((count_reg >> 1) == CNT_W'(i)) begin
                median = cells[i].value;
            end
        end
    end

    assign count_ext = {{FILL_W{1'b0}}, count_reg};
    assign m_tdata = {5'b0, count_ext[FILL_W-1:0], median};
    assign m_tuser = (count_ext >= {{CNT_W{1'b0}}, ready_min_reg});

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(valid_vec) == int'(count_reg)))
        else $error("cell valid bits disagree with fill count");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("sequencer did not start sorting after an accepted item");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// testbench for sliding_window_median_filter: directed fill and wrap tests, then random phases
// depends on swmf_pkg and the rtl of the filter; predicts each result in the bench itself
module tb
    import swmf_pkg::*;
();

    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic                ready;
        logic [FILL_W-1:0]   fill;
    } median_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;      // [7:0] level_sample
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;           // [7:0] median_level, [10:8] fill_count
    logic             m_tuser;           // [0] ready_res
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;     // ready_minimum

    // mirror of the filter state
    logic [SAMPLE_W-1:0] lvl_window [WINDOW];
    int                  lvl_wr_pos = 0;
    int                  lvl_held = 0;
    logic [CFG_W-1:0]    ready_min_shadow = READY_MIN_RESET;
    median_result_t      expected_results [$];

    int          n_errors = 0;
    int          n_checked = 0;
    int          n_settings = 1;
    int          burst_left = 0;
    int          stall_cyc = 0;
    logic [7:0]  level_base = 8'd100;
    logic [7:0]  ramp_lvl = 8'd0;

    sliding_window_median_filter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("sliding_window_median_filter verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic predict_median(input logic [SAMPLE_W-1:0] smp);
        median_result_t      r;
        logic [SAMPLE_W-1:0] srt [WINDOW];
        logic [SAMPLE_W-1:0] key;
        int                  j;
        lvl_window[lvl_wr_pos] = smp;
        lvl_wr_pos = (lvl_wr_pos + 1) % WINDOW;
        if (lvl_held < WINDOW) lvl_held++;
        // while filling, entries 0..held-1 are exactly the valid ones
        for (int i = 0; i < lvl_held; i++) srt[i] = lvl_window[i];
        for (int i = 1; i < lvl_held; i++) begin
            key = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > key) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = key;
        end
        r.median = srt[lvl_held / 2];
        r.ready = (lvl_held >= int'(ready_min_shadow));
        r.fill = FILL_W'(lvl_held);
        expected_results.push_back(r);
    endtask

    // result checker: outputs are stable at the falling edge
    always @(negedge aclk) begin
        median_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
            end else begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (m_tdata[7:0] !== exp_r.median)
                    report_mismatch($sformatf("median_level %0d, want %0d",
                                              m_tdata[7:0], exp_r.median));
                if (m_tdata[10:8] !== exp_r.fill)
                    report_mismatch($sformatf("fill_count %0d, want %0d",
                                              m_tdata[10:8], exp_r.fill));
                if (m_tuser !== exp_r.ready)
                    report_mismatch($sformatf("ready_res %b, want %b", m_tuser, exp_r.ready));
                if (m_tdata[15:11] !== 5'd0)
                    report_mismatch($sformatf("pad bits of tdata %b", m_tdata[15:11]));
            end
        end
    end

    // receiver stalls follow one of four modes in turn
    always @(posedge aclk) begin
        stall_cyc <= stall_cyc + 1;
        case ((stall_cyc / 173) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_cyc % 8 == 0);
            default: m_tready <= (stall_cyc % 5 < 3);
        endcase
    end

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_sample(input logic [7:0] v);
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        predict_median(v);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_ready_min(input logic [CFG_W-1:0] v);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        ready_min_shadow = v;
        n_settings++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 15);
        end
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(0, 255));
            4, 5, 6: return level_base + 8'($urandom_range(0, 8));
            7: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: begin
                ramp_lvl = ramp_lvl + 8'd3;
                return ramp_lvl;
            end
        endcase
    endfunction

    // window filling from reset, with ready_minimum changed part way
    task automatic test_fill_phase();
        send_sample(8'd200);
        send_sample(8'd10);
        write_ready_min(3'd1);
        send_sample(8'd255);
        write_ready_min(3'd7);
        send_sample(8'd0);
        send_sample(8'd128);
        send_sample(8'd127);
        send_sample(8'd255);
    endtask

    // full window: oldest entry overwritten, extremes, duplicates, threshold of zero
    task automatic test_full_window();
        logic [7:0] seq [14] = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                                 8'd1, 8'd254, 8'd128, 8'd127, 8'h55, 8'hAA, 8'd0};
        write_ready_min(3'd0);
        foreach (seq[i]) send_sample(seq[i]);
    endtask

    task automatic test_random_phase(input int n_items, input logic [CFG_W-1:0] rmin);
        write_ready_min(rmin);
        level_base = 8'($urandom_range(0, 255));
        for (int i = 0; i < n_items; i++) begin
            send_sample(pick_level());
            // hold off once per phase until the filter has drained
            if (i == n_items / 2) wait_for_results();
            else pace_sender();
        end
    endtask

    initial begin
        int guard;
        lvl_window = '{default: '0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_phase();
        test_full_window();
        test_random_phase(147, 3'd1);
        test_random_phase(147, 3'd7);
        test_random_phase(147, 3'd0);
        test_random_phase(147, 3'd3);
        test_random_phase(147, 3'd5);
        test_random_phase(147, 3'd2);
        test_random_phase(147, 3'd6);

        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (30) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("checked %0d median results across %0d ready_minimum settings,", n_checked,
                 n_settings);
        $display("covering the fill phase, window wrap, extremes and output stalls");
        if (n_errors == 0) begin
            $display("sliding_window_median_filter verification clean");
        end else begin
            $display("sliding_window_median_filter verification failed");
        end
        $finish;
    end

endmodule
